// ===== design/dsss_pkg.sv =====
// Package with the types, constants and codes shared by the dual stack store files.
`timescale 1ns / 1ps
package dsss_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int OUT_CNT_W   = 11;
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    opcode_e            opcode;
    logic               stack_sel;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    status_e            status;
    logic               lower_empty;
    logic               upper_empty;
    logic               store_full;
    logic [10:0]        lower_count;
    logic [10:0]        upper_count;
  } out_item_t;

  typedef struct packed {
    logic exec;
  } dp_cmd_t;

endpackage

// ===== design/dual_stack_shared_store_unit.sv =====
// Top level of the two stacks that share one element store.
`timescale 1ns / 1ps
// Two stacks share one store of STORE_DEPTH 32-bit entries: the lower stack grows up
// from entry zero and the upper stack grows down from the top entry. Each item pushes,
// pops, peeks or clears one stack and yields exactly one result with the status, the
// element read and both counts. The result of an accepted item is offered from the next
// cycle on; the next item is accepted the cycle after the result is taken. The controller
// holds the input off while a result is offered, because the result is kept in the
// registered read data of the element store and the result register, so a new item is
// not taken before the last result is taken.
module dual_stack_shared_store_unit
  import dsss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t cmd;

  dsss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  dsss_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_item_i (in_item_i),
    .out_item_o(out_item_o)
  );

endmodule

// ===== design/dsss_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module dsss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dsss_ctrl.sv =====
// Controller state machine that sequences item acceptance and result delivery.
`timescale 1ns / 1ps
module dsss_ctrl
  import dsss_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.exec = in_valid_i;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/dsss_datapath.sv =====
// Datapath with the two stack counts, the shared element store and the result register.
`timescale 1ns / 1ps
module dsss_datapath
  import dsss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o
);

  localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(STORE_DEPTH);

  logic [CNT_W-1:0]  lower_q, lower_d;
  logic [CNT_W-1:0]  upper_q, upper_d;
  status_e           status_q, status_d;
  logic              rd_ok_q, rd_ok_d;
  logic [CNT_W:0]    sum;
  logic              full;
  logic [CNT_W-1:0]  sel_cnt;
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  assign sum     = {1'b0, lower_q} + {1'b0, upper_q};
  assign full    = (sum >= DEPTH_C);
  assign sel_cnt = in_item_i.stack_sel ? upper_q : lower_q;

  always_comb begin
    lower_d  = lower_q;
    upper_d  = upper_q;
    status_d = status_q;
    rd_ok_d  = rd_ok_q;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = ADDR_W'(lower_q);
    if (cmd_i.exec) begin
      status_d = ST_OK;
      rd_ok_d  = 1'b0;
      unique case (in_item_i.opcode) inside
        OP_PUSH: begin
          if (full) begin
            status_d = ST_FULL;
          end else if (!in_item_i.stack_sel) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = ADDR_W'(lower_q);
            lower_d  = lower_q + CNT_W'(1);
          end else begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = ADDR_W'(DEPTH_C - (CNT_W + 1)'(1) - {1'b0, upper_q});
            upper_d  = upper_q + CNT_W'(1);
          end
        end
        OP_POP, OP_PEEK: begin
          if (sel_cnt == '0) begin
            status_d = ST_EMPTY;
          end else begin
            ram_en  = 1'b1;
            rd_ok_d = 1'b1;
            if (!in_item_i.stack_sel) begin
              ram_addr = ADDR_W'(lower_q - CNT_W'(1));
              if (in_item_i.opcode == OP_POP) lower_d = lower_q - CNT_W'(1);
            end else begin
              ram_addr = ADDR_W'(DEPTH_C - {1'b0, upper_q});
              if (in_item_i.opcode == OP_POP) upper_d = upper_q - CNT_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          if (!in_item_i.stack_sel) begin
            lower_d = '0;
          end else begin
            upper_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= '0;
      upper_q  <= '0;
      status_q <= ST_OK;
      rd_ok_q  <= 1'b0;
    end else begin
      lower_q  <= lower_d;
      upper_q  <= upper_d;
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  dsss_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(in_item_i.push_value),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    out_item_o.read_value  = rd_ok_q ? ram_rdata : '0;
    out_item_o.status      = status_q;
    out_item_o.lower_empty = (lower_q == '0);
    out_item_o.upper_empty = (upper_q == '0);
    out_item_o.store_full  = full;
    out_item_o.lower_count = OUT_CNT_W'(lower_q);
    out_item_o.upper_count = OUT_CNT_W'(upper_q);
  end

`ifndef SYNTH
  a_occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum <= DEPTH_C)
    else $error("Stack counts exceed the store depth.");

  a_refused_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && in_item_i.opcode == OP_PUSH && full
    |=> $stable(lower_q) && $stable(upper_q) && status_q == ST_FULL)
    else $error("A refused push changed a count.");

  a_empty_read_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (in_item_i.opcode == OP_POP || in_item_i.opcode == OP_PEEK)
    && sel_cnt == '0
    |=> $stable(lower_q) && $stable(upper_q) && status_q == ST_EMPTY && !rd_ok_q)
    else $error("A read of an empty stack changed state.");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(lower_q) && $stable(upper_q) && $stable(status_q))
    else $error("State changed without an item.");
`endif

endmodule

// ===== verif/dual_stack_shared_store_checker.sv =====
// Checker that predicts every result of the dual stack store and compares it with the block.
`timescale 1ns / 1ps
module dual_stack_shared_store_checker
  import dsss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        mismatch_count_o,
  output int        pending_o
);

  localparam int REPORT_MAX = 10;

  logic [DATA_W-1:0] elem_mem [STORE_DEPTH];
  int                lo_fill;
  int                up_fill;
  int                mismatches;
  out_item_t         result_q [$];

  function automatic out_item_t apply_op(input in_item_t it);
    out_item_t r;
    int        sel_fill;
    r        = '0;
    r.status = ST_OK;
    sel_fill = it.stack_sel ? up_fill : lo_fill;
    case (it.opcode) inside
      OP_PUSH: begin
        if (lo_fill + up_fill >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else if (!it.stack_sel) begin
          elem_mem[lo_fill] = it.push_value;
          lo_fill++;
        end else begin
          up_fill++;
          elem_mem[STORE_DEPTH - up_fill] = it.push_value;
        end
      end
      OP_POP, OP_PEEK: begin
        if (sel_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (!it.stack_sel) begin
          r.read_value = elem_mem[lo_fill - 1];
          if (it.opcode == OP_POP) lo_fill--;
        end else begin
          r.read_value = elem_mem[STORE_DEPTH - up_fill];
          if (it.opcode == OP_POP) up_fill--;
        end
      end
      OP_CLEAR: begin
        if (!it.stack_sel) lo_fill = 0;
        else up_fill = 0;
      end
    endcase
    r.lower_empty = (lo_fill == 0);
    r.upper_empty = (up_fill == 0);
    r.store_full  = (lo_fill + up_fill >= STORE_DEPTH);
    r.lower_count = 11'(lo_fill);
    r.upper_count = 11'(up_fill);
    return r;
  endfunction

  function automatic string show(input out_item_t r);
    return $sformatf({"value=%h status=%0d lower_empty=%b upper_empty=%b",
                      " full=%b lower=%0d upper=%0d"},
                     r.read_value, r.status, r.lower_empty, r.upper_empty, r.store_full,
                     r.lower_count, r.upper_count);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      lo_fill    = 0;
      up_fill    = 0;
      mismatches = 0;
      result_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result with none expected: %s", $time, show(out_item_i));
          end
        end else begin
          want = result_q.pop_front();
          if (want.read_value !== out_item_i.read_value || want.status !== out_item_i.status ||
              want.lower_empty !== out_item_i.lower_empty ||
              want.upper_empty !== out_item_i.upper_empty ||
              want.store_full !== out_item_i.store_full ||
              want.lower_count !== out_item_i.lower_count ||
              want.upper_count !== out_item_i.upper_count) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: mismatch expected %s", $time, show(want));
              $display("%0t:          actual   %s", $time, show(out_item_i));
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.push_back(apply_op(in_item_i));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= result_q.size();
  end

endmodule

// ===== verif/dual_stack_shared_store_unit_tb.sv =====
// Testbench top that drives the dual stack store with directed and random items and reports the verdict.
`timescale 1ns / 1ps
module dual_stack_shared_store_unit_tb;
  import dsss_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_CYCLES = 10;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int mismatch_count;
  int pending;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int lo_fill  = 0;
  int up_fill  = 0;

  dual_stack_shared_store_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  dual_stack_shared_store_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_item_i      (out_item_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(input opcode_e op, input logic sel, input logic [31:0] val);
    in_item_t it;
    it.opcode     = op;
    it.stack_sel  = sel;
    it.push_value = val;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    case (op)
      OP_PUSH: begin
        if (lo_fill + up_fill < STORE_DEPTH) begin
          if (sel) up_fill++;
          else lo_fill++;
        end
      end
      OP_POP: begin
        if (sel && up_fill > 0) up_fill--;
        else if (!sel && lo_fill > 0) lo_fill--;
      end
      OP_CLEAR: begin
        if (sel) up_fill = 0;
        else lo_fill = 0;
      end
      default: ;
    endcase
  endtask

  task automatic send_random(input int push_pct, input int pop_pct, input int peek_pct);
    int      roll;
    opcode_e op;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    roll = $urandom_range(0, 99);
    if (roll < push_pct) op = OP_PUSH;
    else if (roll < push_pct + pop_pct) op = OP_POP;
    else if (roll < push_pct + pop_pct + peek_pct) op = OP_PEEK;
    else op = OP_CLEAR;
    send(op, 1'($urandom_range(0, 1)), pick_value());
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("dual_stack_shared_store_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty stacks refuse pops and peeks, then extreme values go in and come back out.
    send(OP_POP, 1'b0, 32'hffff_ffff);
    send(OP_PEEK, 1'b0, 32'h0000_0000);
    send(OP_POP, 1'b1, 32'h8000_0000);
    send(OP_PEEK, 1'b1, 32'h7fff_ffff);
    send(OP_PUSH, 1'b0, 32'h7fff_ffff);
    send(OP_PUSH, 1'b0, 32'h8000_0000);
    send(OP_PUSH, 1'b1, 32'h0000_0000);
    send(OP_PUSH, 1'b1, 32'hffff_ffff);
    send(OP_PEEK, 1'b0, 32'h1234_5678);
    send(OP_PEEK, 1'b1, 32'h1234_5678);
    send(OP_POP, 1'b0, 32'h0);
    send(OP_PEEK, 1'b0, 32'h0);
    send(OP_POP, 1'b1, 32'h0);
    send(OP_POP, 1'b1, 32'h0);
    send(OP_PEEK, 1'b1, 32'h0);
    send(OP_PUSH, 1'b0, 32'h0000_0001);
    send(OP_PUSH, 1'b0, 32'h0000_0002);
    send(OP_CLEAR, 1'b0, 32'hffff_ffff);
    send(OP_PEEK, 1'b0, 32'h0);
    send(OP_PUSH, 1'b1, 32'h0000_0005);
    send(OP_CLEAR, 1'b1, 32'h0);
    send(OP_POP, 1'b1, 32'h0);
    send(OP_CLEAR, 1'b0, 32'h0);
    send(OP_CLEAR, 1'b1, 32'h0);
    wait_drained();

    for (int i = 0; i < 350; i++) begin
      if (i == 120) hold_req = 1'b1;
      if (i == 250 || $urandom_range(0, 99) == 0) wait_drained();
      send_random(40, 25, 20);
    end

    // Fill the shared store to the top, then keep pushing into a full store.
    while (lo_fill + up_fill < STORE_DEPTH) send_random(88, 6, 6);
    for (int i = 0; i < 16; i++) send_random(70, 0, 30);
    send(OP_POP, 1'b0, 32'h0);
    send(OP_PUSH, 1'b1, pick_value());
    send(OP_PUSH, 1'b0, pick_value());
    send(OP_PEEK, 1'b1, 32'h0);

    quiet = 1'b1;
    for (int i = 0; i < 200; i++) send_random(30, 30, 25);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("dual_stack_shared_store_unit regression: pass");
    end else begin
      $display("dual_stack_shared_store_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== dual_stack_shared_store_unit.f =====
design/dsss_pkg.sv
design/dsss_ram.sv
design/dsss_ctrl.sv
design/dsss_datapath.sv
design/dual_stack_shared_store_unit.sv
verif/dual_stack_shared_store_checker.sv
verif/dual_stack_shared_store_unit_tb.sv
